@@ design/token_lcs_error_counter_assert.svh @@
// Assertion macros shared by the token LCS error counter
`ifndef TOKEN_LCS_ERROR_COUNTER_ASSERT_SVH
`define TOKEN_LCS_ERROR_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define TLCS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset
`define TLCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/tlcs_pkg.sv @@
// Package: constants, function codes and chain types for the token LCS error counter
package tlcs_pkg;

  localparam int unsigned MAX_TOKENS = 32;
  localparam int unsigned CNT_W      = $clog2(MAX_TOKENS + 1);
  localparam int unsigned CODE_W     = 32;
  localparam int unsigned RES_W      = 6;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_ANALYSE = 2'd1,
    FUNC_FINISH  = 2'd2
  } func_e;

  // Reference token as written into a cell
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              sym;
  } ref_tok_t;

  // Wavefront handed from one cell to the next
  typedef struct packed {
    logic              vld;
    logic [CODE_W-1:0] code;
    logic              sym;
    logic [CNT_W-1:0]  diag;
    logic [CNT_W-1:0]  left;
  } wave_t;

endpackage

@@ design/token_lcs_error_counter.sv @@
// Top level: token LCS error counter over a chain of DP cells
// Load and finish beats do not make the block busy; a finish result is registered and shows the next cycle.
// An analysed token makes the block busy: its wave steps one cell per cycle
// along the chain, and the next beat is taken once the wave has left the tail.
// Asynchronous active-low reset clears counts, flags, DP values and the running total;
// stored reference codes stay undefined until loaded.
`include "token_lcs_error_counter_assert.svh"

module token_lcs_error_counter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   func_i,
  input  logic [tlcs_pkg::CODE_W-1:0]  token_code_i,
  input  logic                         token_is_symbol_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tlcs_pkg::RES_W-1:0]   lcs_length_o,
  output logic [tlcs_pkg::RES_W-1:0]   block_errors_o,
  output logic [tlcs_pkg::CODE_W-1:0]  total_errors_o,
  output logic                         overflow_o
);
  import tlcs_pkg::*;

  logic [CNT_W-1:0]  ref_count_q, ref_count_d;
  logic [CNT_W-1:0]  ana_count_q, ana_count_d;
  logic [CNT_W-1:0]  lcs_q, lcs_d;
  logic              dropped_q, dropped_d;
  logic              busy_q, busy_d;
  logic [CODE_W-1:0] total_q, total_d;
  logic              out_valid_q, out_valid_d;
  logic [RES_W-1:0]  lcs_out_q, err_out_q;
  logic              ovf_out_q;

  logic              in_fire, is_load, is_ana, is_fin;
  logic              load_go, ana_go, clear;
  logic [CNT_W-1:0]  errs;
  logic [CODE_W:0]   sum;
  logic [CNT_W+RES_W-1:0] lcs_ext, err_ext;
  ref_tok_t          load_tok;
  wave_t             wave_in, wave_tail;

  // Beat decode
  assign is_load = (func_i == FUNC_LOAD);
  assign is_ana  = (func_i == FUNC_ANALYSE);
  assign is_fin  = (func_i == FUNC_FINISH);

  // Hold off while a wave runs, or a finish while the result slot is still full
  assign in_ready_o = !busy_q && (!is_fin || !out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  assign load_go = in_fire && is_load && (ana_count_q == '0) &&
                   (ref_count_q < CNT_W'(MAX_TOKENS));
  assign ana_go  = in_fire && is_ana && (ana_count_q < CNT_W'(MAX_TOKENS));
  assign clear   = in_fire && is_fin;

  assign load_tok.code = token_code_i;
  assign load_tok.sym  = token_is_symbol_i;

  always_comb begin
    wave_in.vld  = ana_go;
    wave_in.code = token_code_i;
    wave_in.sym  = token_is_symbol_i;
    wave_in.diag = '0;
    wave_in.left = '0;
  end

  tlcs_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (clear),
    .load_i      (load_go),
    .load_slot_i (ref_count_q),
    .load_tok_i  (load_tok),
    .wave_i      (wave_in),
    .wave_o      (wave_tail)
  );

  // Block result and saturating total
  assign errs    = ref_count_q - lcs_q;
  assign sum     = {1'b0, total_q} + (CODE_W+1)'(errs);
  assign lcs_ext = {{RES_W{1'b0}}, lcs_q};
  assign err_ext = {{RES_W{1'b0}}, errs};

  // Control next state
  always_comb begin
    ref_count_d = ref_count_q;
    ana_count_d = ana_count_q;
    lcs_d       = lcs_q;
    dropped_d   = dropped_q;
    busy_d      = busy_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (wave_tail.vld) begin
      busy_d = 1'b0;
      lcs_d  = wave_tail.left;
    end
    if (load_go) begin
      ref_count_d = ref_count_q + CNT_W'(1);
    end
    if (ana_go) begin
      ana_count_d = ana_count_q + CNT_W'(1);
      busy_d      = 1'b1;
    end
    // Full lists drop the token and flag it
    if (in_fire && is_load && (ana_count_q == '0) && !(ref_count_q < CNT_W'(MAX_TOKENS))) begin
      dropped_d = 1'b1;
    end
    if (in_fire && is_ana && !(ana_count_q < CNT_W'(MAX_TOKENS))) begin
      dropped_d = 1'b1;
    end
    if (clear) begin
      total_d     = sum[CODE_W] ? {CODE_W{1'b1}} : sum[CODE_W-1:0];
      out_valid_d = 1'b1;
      ref_count_d = '0;
      ana_count_d = '0;
      lcs_d       = '0;
      dropped_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_count_q <= '0;
      ana_count_q <= '0;
      lcs_q       <= '0;
      dropped_q   <= 1'b0;
      busy_q      <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ref_count_q <= ref_count_d;
      ana_count_q <= ana_count_d;
      lcs_q       <= lcs_d;
      dropped_q   <= dropped_d;
      busy_q      <= busy_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (clear) begin
      lcs_out_q <= lcs_ext[RES_W-1:0];
      err_out_q <= err_ext[RES_W-1:0];
      ovf_out_q <= dropped_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign lcs_length_o   = lcs_out_q;
  assign block_errors_o = err_out_q;
  assign total_errors_o = total_q;
  assign overflow_o     = ovf_out_q;

  // Checks
  `TLCS_ASSERT_IMPL(a_tail_while_busy, wave_tail.vld, busy_q)
  `TLCS_ASSERT_IMPL(a_ref_count_bound, 1'b1, ref_count_q <= CNT_W'(MAX_TOKENS))
  `TLCS_ASSERT_NEXT(a_finish_emits, clear, out_valid_o)
  `TLCS_ASSERT_IMPL(a_no_beat_while_busy, busy_q, !in_ready_o)

endmodule

@@ design/tlcs_cell.sv @@
// One DP cell: holds a reference token and its row value, updates it as a wave passes
module tlcs_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              load_en_i,
  input  tlcs_pkg::ref_tok_t load_tok_i,
  input  tlcs_pkg::wave_t   wave_i,
  output tlcs_pkg::wave_t   wave_o
);
  import tlcs_pkg::*;

  logic              loaded_q, loaded_d;
  logic [CODE_W-1:0] code_q;
  logic              sym_q;
  logic [CNT_W-1:0]  dp_q, dp_d;
  logic              wave_vld_q;
  logic [CODE_W-1:0] wave_code_q;
  logic              wave_sym_q;
  logic [CNT_W-1:0]  wave_diag_q, wave_left_q;
  wave_t             wave_d;
  logic              hit;
  logic [CNT_W-1:0]  val;

  // Match and LCS recurrence for this column
  always_comb begin
    hit = (code_q == wave_i.code) || (sym_q && wave_i.sym);
    if (hit) begin
      val = wave_i.diag + CNT_W'(1);
    end else if (dp_q > wave_i.left) begin
      val = dp_q;
    end else begin
      val = wave_i.left;
    end
  end

  // Next state; unloaded cells pass the wave straight on
  always_comb begin
    loaded_d = loaded_q;
    dp_d     = dp_q;
    wave_d   = wave_i;
    if (clear_i) begin
      loaded_d = 1'b0;
      dp_d     = '0;
    end else if (load_en_i) begin
      loaded_d = 1'b1;
    end
    if (wave_i.vld && loaded_q) begin
      dp_d        = val;
      wave_d.diag = dp_q;
      wave_d.left = val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q   <= 1'b0;
      dp_q       <= '0;
      wave_vld_q <= 1'b0;
    end else begin
      loaded_q   <= loaded_d;
      dp_q       <= dp_d;
      wave_vld_q <= wave_d.vld;
    end
  end

  // Token and wave payload carry no reset
  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      code_q <= load_tok_i.code;
      sym_q  <= load_tok_i.sym;
    end
    wave_code_q <= wave_d.code;
    wave_sym_q  <= wave_d.sym;
    wave_diag_q <= wave_d.diag;
    wave_left_q <= wave_d.left;
  end

  always_comb begin
    wave_o.vld  = wave_vld_q;
    wave_o.code = wave_code_q;
    wave_o.sym  = wave_sym_q;
    wave_o.diag = wave_diag_q;
    wave_o.left = wave_left_q;
  end

endmodule

@@ design/tlcs_chain.sv @@
// Row of DP cells with load-slot decode; the wave enters at cell 0 and leaves at the tail
module tlcs_chain (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        load_i,
  input  logic [tlcs_pkg::CNT_W-1:0]  load_slot_i,
  input  tlcs_pkg::ref_tok_t          load_tok_i,
  input  tlcs_pkg::wave_t             wave_i,
  output tlcs_pkg::wave_t             wave_o
);
  import tlcs_pkg::*;

  wave_t wave [MAX_TOKENS+1];

  assign wave[0] = wave_i;

  for (genvar i = 0; i < MAX_TOKENS; i++) begin : g_cell
    logic load_en;
    // Write the cell whose index equals the current reference count
    assign load_en = load_i && (load_slot_i == CNT_W'(i));

    tlcs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clear_i    (clear_i),
      .load_en_i  (load_en),
      .load_tok_i (load_tok_i),
      .wave_i     (wave[i]),
      .wave_o     (wave[i+1])
    );
  end

  assign wave_o = wave[MAX_TOKENS];

endmodule

@@ dv/token_lcs_error_counter_tb.sv @@
// Testbench for the token LCS error counter: directed and random token blocks checked against a DP row model
`timescale 1ns / 1ps

module token_lcs_error_counter_tb;
  import tlcs_pkg::*;

  localparam logic [1:0] FUNC_SPARE   = 2'd3;  // unused code, block must ignore it
  localparam int unsigned ITEM_TARGET  = 1400;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned IDX_W        = $clog2(MAX_TOKENS);

  typedef struct packed {
    logic [RES_W-1:0]  lcs;
    logic [RES_W-1:0]  errs;
    logic [CODE_W-1:0] total;
    logic              ovf;
  } block_score_t;

  logic              clk_i             = 1'b0;
  logic              rst_ni            = 1'b0;
  logic              in_valid_i        = 1'b0;
  logic              in_ready_o;
  logic [1:0]        func_i            = FUNC_LOAD;
  logic [CODE_W-1:0] token_code_i      = '0;
  logic              token_is_symbol_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i       = 1'b0;
  logic [RES_W-1:0]  lcs_length_o;
  logic [RES_W-1:0]  block_errors_o;
  logic [CODE_W-1:0] total_errors_o;
  logic              overflow_o;

  // Row model of the block
  ref_tok_t          ref_list [MAX_TOKENS];
  logic [CNT_W-1:0]  lcs_row [MAX_TOKENS];
  logic [CNT_W-1:0]  ref_cnt;
  logic [CNT_W-1:0]  ana_cnt;
  logic [CODE_W-1:0] err_total;
  logic              dropped;

  block_score_t pending_scores [$];
  int unsigned  err_cnt     = 0;
  int unsigned  cycle_cnt   = 0;
  int unsigned  items_sent  = 0;
  int unsigned  idle_pct    = 0;
  int unsigned  stall_pct   = 0;

  token_lcs_error_counter DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .token_code_i      (token_code_i),
    .token_is_symbol_i (token_is_symbol_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .lcs_length_o      (lcs_length_o),
    .block_errors_o    (block_errors_o),
    .total_errors_o    (total_errors_o),
    .overflow_o        (overflow_o)
  );

  always #1 clk_i = ~clk_i;

  // Run-length guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void clear_block_model();
    ref_cnt = '0;
    ana_cnt = '0;
    dropped = 1'b0;
    for (int i = 0; i < MAX_TOKENS; i++) lcs_row[i] = '0;
  endfunction

  // Advance the model by one accepted beat; a finish queues the block score
  function automatic void apply_token_beat(input logic [1:0] func, input logic [CODE_W-1:0] code,
                                           input logic sym);
    logic [CNT_W-1:0] diag;
    logic [CNT_W-1:0] left;
    logic [CNT_W-1:0] above;
    logic [CNT_W-1:0] val;
    logic [CODE_W:0]  sum;
    block_score_t     sc;
    case (func)
      FUNC_LOAD: begin
        // late reference tokens are ignored without a flag
        if (ana_cnt == 0) begin
          if (ref_cnt >= CNT_W'(MAX_TOKENS)) begin
            dropped = 1'b1;
          end else begin
            ref_list[IDX_W'(ref_cnt)].code = code;
            ref_list[IDX_W'(ref_cnt)].sym  = sym;
            ref_cnt++;
          end
        end
      end
      FUNC_ANALYSE: begin
        if (ana_cnt >= CNT_W'(MAX_TOKENS)) begin
          dropped = 1'b1;
        end else begin
          diag = '0;
          left = '0;
          for (int i = 0; i < ref_cnt; i++) begin
            above = lcs_row[i];
            if (ref_list[i].code == code || (ref_list[i].sym && sym))
              val = diag + CNT_W'(1);
            else
              val = (above > left) ? above : left;
            diag       = above;
            left       = val;
            lcs_row[i] = val;
          end
          ana_cnt++;
        end
      end
      FUNC_FINISH: begin
        sc.lcs    = (ref_cnt != 0) ? lcs_row[IDX_W'(ref_cnt - CNT_W'(1))] : '0;
        sc.errs   = ref_cnt - sc.lcs;
        sum       = {1'b0, err_total} + (CODE_W+1)'(sc.errs);
        err_total = sum[CODE_W] ? '1 : sum[CODE_W-1:0];
        sc.total  = err_total;
        sc.ovf    = dropped;
        pending_scores.push_back(sc);
        clear_block_model();
      end
      default: ;
    endcase
  endfunction

  // One beat on the input channel; called and returning at a falling edge
  task automatic send_beat(input logic [1:0] func, input logic [CODE_W-1:0] code,
                           input logic sym);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    func_i            <= func;
    token_code_i      <= code;
    token_is_symbol_i <= sym;
    do @(posedge clk_i); while (!in_ready_o);
    apply_token_beat(func, code, sym);
    @(negedge clk_i);
  endtask

  // Hold the sender off until every queued score has been taken
  task automatic wait_scores_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_scores.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [CODE_W-1:0] exp_v,
                             input logic [CODE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Score checker
  always @(posedge clk_i) begin
    block_score_t sc;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_scores.size() == 0) begin
        $display("%0t: unexpected score, expected none actual lcs %0d errs %0d total %0d",
                 $time, lcs_length_o, block_errors_o, total_errors_o);
        err_cnt++;
      end else begin
        sc = pending_scores.pop_front();
        check_field("lcs_length", CODE_W'(sc.lcs), CODE_W'(lcs_length_o));
        check_field("block_errors", CODE_W'(sc.errs), CODE_W'(block_errors_o));
        check_field("total_errors", sc.total, total_errors_o);
        check_field("overflow", CODE_W'(sc.ovf), CODE_W'(overflow_o));
      end
    end
  end

  function automatic logic [CODE_W-1:0] rand_code();
    int unsigned sel;
    sel = $urandom_range(99);
    // a small alphabet keeps matches frequent
    if (sel < 70) return $urandom_range(5);
    if (sel < 85) return $urandom;
    return ~$urandom_range(3);
  endfunction

  function automatic logic rand_sym();
    return ($urandom_range(99) < 20);
  endfunction

  function automatic int unsigned rand_list_len();
    if ($urandom_range(99) < 8) return $urandom_range(MAX_TOKENS + 4);
    return $urandom_range(8);
  endfunction

  // Beats the block should ignore or that break a block's shape
  task automatic send_noise();
    if ($urandom_range(1))
      send_beat(FUNC_SPARE, $urandom, 1'($urandom_range(1)));
    else
      send_beat(FUNC_LOAD, rand_code(), rand_sym());
  endtask

  // Extreme codes and the symbol match rule
  task automatic test_matching();
    send_beat(FUNC_LOAD, 32'h0000_0000, 1'b0);
    send_beat(FUNC_LOAD, 32'hFFFF_FFFF, 1'b0);
    send_beat(FUNC_LOAD, 32'h0000_0005, 1'b1);
    send_beat(FUNC_ANALYSE, 32'hFFFF_FFFF, 1'b0);
    send_beat(FUNC_ANALYSE, 32'h0000_0007, 1'b1);
    send_beat(FUNC_ANALYSE, 32'h0000_0000, 1'b1);
    send_beat(FUNC_FINISH, 32'h0, 1'b0);
  endtask

  // Finish with one or both lists empty
  task automatic test_empty_lists();
    send_beat(FUNC_FINISH, 32'h0, 1'b0);
    send_beat(FUNC_LOAD, 32'h1, 1'b0);
    send_beat(FUNC_LOAD, 32'h2, 1'b0);
    send_beat(FUNC_LOAD, 32'h3, 1'b1);
    send_beat(FUNC_FINISH, 32'h0, 1'b0);
    send_beat(FUNC_ANALYSE, 32'h1, 1'b1);
    send_beat(FUNC_ANALYSE, 32'h2, 1'b0);
    send_beat(FUNC_FINISH, 32'h0, 1'b0);
  endtask

  // Reference beat after analysis has started is ignored
  task automatic test_late_reference();
    send_beat(FUNC_LOAD, 32'h9, 1'b0);
    send_beat(FUNC_ANALYSE, 32'h4, 1'b0);
    send_beat(FUNC_LOAD, 32'h4, 1'b0);
    send_beat(FUNC_FINISH, 32'h0, 1'b0);
  endtask

  // Unused function code
  task automatic test_spare_code();
    send_beat(FUNC_SPARE, 32'hFFFF_FFFF, 1'b1);
    send_beat(FUNC_SPARE, 32'h0, 1'b0);
    send_beat(FUNC_FINISH, 32'h0, 1'b0);
  endtask

  // Both lists past capacity, then the reference list alone
  task automatic test_full_lists();
    for (int k = 0; k < MAX_TOKENS + 2; k++) send_beat(FUNC_LOAD, rand_code(), rand_sym());
    for (int k = 0; k < MAX_TOKENS + 2; k++) send_beat(FUNC_ANALYSE, rand_code(), rand_sym());
    send_beat(FUNC_FINISH, 32'h0, 1'b0);
    for (int k = 0; k < MAX_TOKENS + 1; k++) send_beat(FUNC_LOAD, rand_code(), rand_sym());
    send_beat(FUNC_FINISH, 32'h0, 1'b0);
    items_sent += 3 * MAX_TOKENS + 7;
  endtask

  // Well-formed blocks with random content, a little noise and some unfinished blocks
  task automatic test_random_blocks(input int unsigned quota);
    int unsigned stop_at;
    int unsigned nref;
    int unsigned nana;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      nref = rand_list_len();
      nana = rand_list_len();
      for (int k = 0; k < nref; k++) begin
        send_beat(FUNC_LOAD, rand_code(), rand_sym());
        items_sent++;
      end
      for (int k = 0; k < nana; k++) begin
        if ($urandom_range(99) < 5) send_noise();
        send_beat(FUNC_ANALYSE, rand_code(), rand_sym());
        items_sent++;
      end
      if ($urandom_range(99) < 5) send_noise();
      if ($urandom_range(99) < 94) begin
        send_beat(FUNC_FINISH, $urandom, 1'($urandom_range(1)));
        items_sent++;
      end
    end
  endtask

  initial begin
    err_total = '0;
    clear_block_model();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_matching();
    test_empty_lists();
    test_late_reference();
    test_spare_code();
    test_full_lists();

    // idling phases: none, sender, receiver, both
    idle_pct = 0;  stall_pct = 0;
    test_random_blocks(ITEM_TARGET / 4);
    wait_scores_drained();
    idle_pct = 45; stall_pct = 0;
    test_random_blocks(ITEM_TARGET / 4);
    wait_scores_drained();
    idle_pct = 0;  stall_pct = 45;
    test_random_blocks(ITEM_TARGET / 4);
    wait_scores_drained();
    idle_pct = 29; stall_pct = 29;
    test_random_blocks(ITEM_TARGET / 4);
    send_beat(FUNC_FINISH, 32'h0, 1'b0);

    wait_scores_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && pending_scores.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
